// File: rtl/shfc_pkg.sv
// Package for the single/half float converter.
// Holds the class codes, stage record types and format constants; no dependencies.
`default_nettype none

package shfc_pkg;

   localparam int unsigned FUNC_W  = 1;
   localparam int unsigned VALUE_W = 32;

   // direction codes
   localparam logic FUNC_TO_HALF   = 1'b0;
   localparam logic FUNC_TO_SINGLE = 1'b1;

   localparam logic [14:0] HALF_QNAN   = 15'h7E00;
   localparam logic [14:0] HALF_INF    = 15'h7C00;
   localparam logic [30:0] SINGLE_QNAN = 31'h7FC0_0000;
   localparam logic [30:0] SINGLE_INF  = 31'h7F80_0000;
   localparam logic [7:0]  LOW_EXP     = 8'd113;
   localparam logic [7:0]  HIGH_EXP    = 8'd142;
   localparam logic [7:0]  EXP_REBIAS  = 8'd112;
   localparam logic [7:0]  SUB_EXP_BASE = 8'd103;
   localparam logic [3:0]  MAX_SHIFT   = 4'd11;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_NORM,
      CLS_SUB,
      CLS_INF,
      CLS_NAN
   } class_type;

   // decoded operand
   typedef struct packed {
      logic        func;
      logic        sign;
      class_type   cls;
      logic [7:0]  exp;
      logic [22:0] man;
      logic [3:0]  shift;   // right shift (to half) or leading-one index (to single)
   } dec_type;

   // assembled magnitude, sign and class still pending final select
   typedef struct packed {
      logic        func;
      logic        sign;
      class_type   cls;
      logic        rnd;
      logic [30:0] body;
   } asm_type;

endpackage

`default_nettype wire

// File: rtl/single_half_float_converter_top.sv
// Top level of the single/half float converter: a three-stage pipeline.
// Depends on shfc_pkg.
//
// Each request passes the classify, rebias and round registers before rsp_valid.
// Throughput: one request per cycle unless rsp stalls; a stall holds only full stages.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none

module single_half_float_converter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [31:0] req_value_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_bits
);

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   shfc_pkg::dec_type dec_ff, dec_in;
   shfc_pkg::asm_type asm_ff, asm_in;
   logic [31:0]       res_ff, res_in;

   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v3_ff;
   assign rsp_result_bits = res_ff;

   // ---------------- stage 1: classify ----------------
   always_comb begin
      logic [7:0] e8;
      logic [4:0] e5;
      logic [9:0] m10;
      logic [7:0] sh;
      dec_in       = '0;
      dec_in.func  = req_func;
      e8           = req_value_bits[30:23];
      e5           = req_value_bits[14:10];
      m10          = req_value_bits[9:0];
      sh           = shfc_pkg::LOW_EXP - e8;
      if (req_func == shfc_pkg::FUNC_TO_HALF) begin
         dec_in.sign = req_value_bits[31];
         dec_in.exp  = e8;
         dec_in.man  = req_value_bits[22:0];
         if (e8 == 8'hFF) begin
            dec_in.cls = (req_value_bits[22:0] != '0) ? shfc_pkg::CLS_NAN
                                                      : shfc_pkg::CLS_INF;
         end else if (e8 >= shfc_pkg::LOW_EXP && e8 <= shfc_pkg::HIGH_EXP) begin
            dec_in.cls = shfc_pkg::CLS_NORM;
         end else if (e8 == '0) begin
            dec_in.cls = shfc_pkg::CLS_ZERO;
         end else if (e8 < shfc_pkg::LOW_EXP) begin
            dec_in.cls = shfc_pkg::CLS_SUB;
         end else begin
            dec_in.cls = shfc_pkg::CLS_INF;
         end
         // anything shifted by 11 or more is gone
         dec_in.shift = (sh >= 8'(shfc_pkg::MAX_SHIFT)) ? shfc_pkg::MAX_SHIFT : sh[3:0];
      end else begin
         dec_in.sign = req_value_bits[15];
         dec_in.exp  = {3'b000, e5};
         dec_in.man  = {13'b0, m10};
         if (e5 == 5'h1F) begin
            dec_in.cls = (m10 != '0) ? shfc_pkg::CLS_NAN : shfc_pkg::CLS_INF;
         end else if (e5 != '0) begin
            dec_in.cls = shfc_pkg::CLS_NORM;
         end else if (m10 == '0) begin
            dec_in.cls = shfc_pkg::CLS_ZERO;
         end else begin
            dec_in.cls = shfc_pkg::CLS_SUB;
         end
         // leading-one index
         dec_in.shift = '0;
         for (int i = 0; i < 10; i++) begin
            if (m10[i]) dec_in.shift = 4'(i);
         end
      end
   end

   // ---------------- stage 2: rebias and shift ----------------
   always_comb begin
      logic [10:0] sub_h;
      logic [22:0] sub_s;
      logic [3:0]  lsh;
      asm_in      = '0;
      asm_in.func = dec_ff.func;
      asm_in.sign = dec_ff.sign;
      asm_in.cls  = dec_ff.cls;
      sub_h       = {1'b1, dec_ff.man[22:13]} >> dec_ff.shift;
      lsh         = 4'd10 - dec_ff.shift;
      sub_s       = {dec_ff.man[9:0], 13'b0} << lsh;
      if (dec_ff.func == shfc_pkg::FUNC_TO_HALF) begin
         asm_in.rnd = dec_ff.man[12];
         if (dec_ff.cls == shfc_pkg::CLS_NORM) begin
            asm_in.body = {16'b0, 5'(dec_ff.exp - shfc_pkg::EXP_REBIAS), dec_ff.man[22:13]};
         end else begin
            asm_in.body = {20'b0, sub_h};
         end
      end else begin
         if (dec_ff.cls == shfc_pkg::CLS_NORM) begin
            asm_in.body = {dec_ff.exp + shfc_pkg::EXP_REBIAS, dec_ff.man[9:0], 13'b0};
         end else begin
            asm_in.body = {shfc_pkg::SUB_EXP_BASE + {4'b0, dec_ff.shift}, sub_s};
         end
      end
   end

   // ---------------- stage 3: round and select ----------------
   always_comb begin
      logic [14:0] mag;
      if (asm_ff.func == shfc_pkg::FUNC_TO_HALF) begin
         case (asm_ff.cls)
            shfc_pkg::CLS_NORM: mag = asm_ff.body[14:0] + 15'(asm_ff.rnd);
            shfc_pkg::CLS_SUB:  mag = asm_ff.body[14:0];
            shfc_pkg::CLS_INF:  mag = shfc_pkg::HALF_INF;
            shfc_pkg::CLS_NAN:  mag = shfc_pkg::HALF_QNAN;
            default:            mag = '0;
         endcase
         res_in = {16'b0, asm_ff.sign, mag};
      end else begin
         mag = '0;
         case (asm_ff.cls)
            shfc_pkg::CLS_NORM,
            shfc_pkg::CLS_SUB:  res_in = {asm_ff.sign, asm_ff.body};
            shfc_pkg::CLS_INF:  res_in = {asm_ff.sign, shfc_pkg::SINGLE_INF};
            shfc_pkg::CLS_NAN:  res_in = {asm_ff.sign, shfc_pkg::SINGLE_QNAN};
            default:            res_in = {asm_ff.sign, 31'b0};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) dec_ff <= dec_in;
      if (adv2) asm_ff <= asm_in;
      if (adv3) res_ff <= res_in;
   end

endmodule

`default_nettype wire

// File: test/shfc_checker.sv
// Checker for the single/half float converter: predicts each conversion and compares responses.
// Depends on shfc_pkg for the direction codes; watches the req_ and rsp_ channels only.
module shfc_checker
   import shfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_func,
   input  logic [31:0]       req_value_bits,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [31:0]       rsp_result_bits,
   output int unsigned       awaited,
   output int unsigned       mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [14:0] HALF_NAN_BITS   = 15'h7E00;
   localparam logic [14:0] HALF_INF_BITS   = 15'h7C00;
   localparam logic [30:0] SINGLE_NAN_BITS = 31'h7FC0_0000;
   localparam logic [30:0] SINGLE_INF_BITS = 31'h7F80_0000;
   localparam logic [7:0]  BIAS_DELTA      = 8'd112;
   localparam logic [7:0]  NORMAL_LO       = 8'd113;
   localparam logic [7:0]  NORMAL_HI       = 8'd142;
   localparam logic [7:0]  DENORM_BASE     = 8'd103;

   logic [31:0] expected_conversions[$];

   initial begin
      awaited    = 0;
      mismatches = 0;
   end

   function automatic logic [15:0] narrow_to_half(input logic [31:0] x);
      logic        sgn;
      logic [7:0]  ex;
      logic [9:0]  man;
      logic [7:0]  rebiased;
      logic [7:0]  shift;
      logic [31:0] sub;
      logic [15:0] h;
      sgn = x[31];
      ex  = x[30:23];
      man = x[22:13];
      if (ex == 8'hFF) begin
         h = (x[22:0] != 23'd0) ? {sgn, HALF_NAN_BITS} : {sgn, HALF_INF_BITS};
      end else if (ex >= NORMAL_LO && ex <= NORMAL_HI) begin
         rebiased = ex - BIAS_DELTA;
         // rounding carry may ripple into the exponent, up to infinity
         h = {sgn, rebiased[4:0], man} + {15'd0, x[12]};
      end else if (ex == 8'd0) begin
         h = {sgn, 15'd0};
      end else if (ex < NORMAL_LO) begin
         shift = NORMAL_LO - ex;
         sub   = (shift >= 8'd32) ? 32'd0 : ({21'd0, 1'b1, man} >> shift);
         h     = {sgn, sub[14:0]};
      end else begin
         h = {sgn, HALF_INF_BITS};
      end
      return h;
   endfunction

   function automatic logic [31:0] widen_to_single(input logic [15:0] x);
      logic        sgn;
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [7:0]  lead;
      logic [7:0]  ex8;
      logic [31:0] frac;
      logic [31:0] r;
      sgn = x[15];
      ex  = x[14:10];
      man = x[9:0];
      if (ex == 5'h1F) begin
         r = (man != 10'd0) ? {sgn, SINGLE_NAN_BITS} : {sgn, SINGLE_INF_BITS};
      end else if (ex != 5'd0) begin
         ex8 = {3'd0, ex} + BIAS_DELTA;
         r   = {sgn, ex8, man, 13'd0};
      end else if (man == 10'd0) begin
         r = {sgn, 31'd0};
      end else begin
         lead = 8'd0;
         for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
               lead = 8'(i);
            end
         end
         // normalize: leading one lands on bit 23 and is dropped
         frac = {22'd0, man} << (8'd23 - lead);
         ex8  = DENORM_BASE + lead;
         r    = {sgn, ex8, frac[22:0]};
      end
      return r;
   endfunction

   function automatic logic [31:0] converted_value(input logic f, input logic [31:0] v);
      if (f == FUNC_TO_SINGLE) begin
         return widen_to_single(v[15:0]);
      end
      return {16'd0, narrow_to_half(v)};
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_conversions.push_back(converted_value(req_func, req_value_bits));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_conversions.size() == 0) begin
               $error("unexpected response: result_bits %h", rsp_result_bits);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_conversions.pop_front();
               if (rsp_result_bits !== want) begin
                  $error("result_bits: expected %h, actual %h", want, rsp_result_bits);
                  mismatches <= mismatches + 1;
               end
            end
         end
         awaited <= expected_conversions.size();
      end
   end

endmodule

// File: test/tb_top.sv
// Testbench top for the single/half float converter: clock, reset, request stimulus, verdict.
// Depends on shfc_pkg, single_half_float_converter_top and shfc_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS = 1200;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned DIRECTED_COUNT  = 26;

   // {func, value_bits}
   localparam logic [32:0] DIRECTED [DIRECTED_COUNT] = '{
      {shfc_pkg::FUNC_TO_HALF,   32'h0000_0000},   // zero
      {shfc_pkg::FUNC_TO_HALF,   32'h8000_0001},   // single subnormal flushes
      {shfc_pkg::FUNC_TO_HALF,   32'h0080_0000},   // smallest exponent, huge shift
      {shfc_pkg::FUNC_TO_HALF,   32'h28FF_FFFF},   // shift of exactly 32
      {shfc_pkg::FUNC_TO_HALF,   32'h297F_FFFF},   // shift of 31
      {shfc_pkg::FUNC_TO_HALF,   32'h387F_FFFF},   // largest half subnormal
      {shfc_pkg::FUNC_TO_HALF,   32'hB3A0_0000},
      {shfc_pkg::FUNC_TO_HALF,   32'h3880_1000},   // lowest normal, rounded up
      {shfc_pkg::FUNC_TO_HALF,   32'h3F80_0000},
      {shfc_pkg::FUNC_TO_HALF,   32'h3FFF_F000},   // round carries into exponent
      {shfc_pkg::FUNC_TO_HALF,   32'h477F_F000},   // round carries to infinity
      {shfc_pkg::FUNC_TO_HALF,   32'hC77F_F000},
      {shfc_pkg::FUNC_TO_HALF,   32'h477F_E000},   // largest finite half
      {shfc_pkg::FUNC_TO_HALF,   32'h4780_0000},   // first overflow exponent
      {shfc_pkg::FUNC_TO_HALF,   32'h7F7F_FFFF},
      {shfc_pkg::FUNC_TO_HALF,   32'hFF80_0000},   // infinity
      {shfc_pkg::FUNC_TO_HALF,   32'h7F80_0001},   // NaN
      {shfc_pkg::FUNC_TO_HALF,   32'hFFC0_0000},
      {shfc_pkg::FUNC_TO_SINGLE, 32'h0000_0000},
      {shfc_pkg::FUNC_TO_SINGLE, 32'hFFFF_8000},   // upper half ignored
      {shfc_pkg::FUNC_TO_SINGLE, 32'h0000_0001},   // smallest half subnormal
      {shfc_pkg::FUNC_TO_SINGLE, 32'h1234_03FF},
      {shfc_pkg::FUNC_TO_SINGLE, 32'h0000_7BFF},
      {shfc_pkg::FUNC_TO_SINGLE, 32'h0000_FC00},
      {shfc_pkg::FUNC_TO_SINGLE, 32'h0000_7C01},
      {shfc_pkg::FUNC_TO_SINGLE, 32'hABCD_FE00}
   };

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_func       = shfc_pkg::FUNC_TO_HALF;
   logic [31:0] req_value_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_result_bits;
   logic        steady         = 1'b0;
   int unsigned cycles         = 0;
   int unsigned awaited;
   int unsigned mismatches;

   always #5 clock = ~clock;

   single_half_float_converter_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value_bits  (req_value_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_bits (rsp_result_bits)
   );

   shfc_checker conversion_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value_bits  (req_value_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_bits (rsp_result_bits),
      .awaited         (awaited),
      .mismatches      (mismatches)
   );

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_request(input logic f, input logic [31:0] v);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_value_bits <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   // mostly steered toward each exponent class, with some raw patterns
   function automatic logic [32:0] random_request();
      logic [31:0] v;
      logic [7:0]  ex;
      logic [4:0]  hex;
      v = $urandom;
      if ($urandom_range(1) == 0) begin
         case ($urandom_range(9))
            0: ex = 8'd0;
            1: ex = 8'($urandom_range(112, 1));
            2, 3, 4: ex = 8'($urandom_range(142, 113));
            5: ex = 8'($urandom_range(254, 143));
            6: begin
               ex = 8'd255;
               if ($urandom_range(1) == 0) v[22:0] = 23'd0;
            end
            7: ex = 8'($urandom_range(84, 80));
            8: begin
               ex = 8'($urandom_range(142, 139));
               v[22:12] = '1;
            end
            default: ex = v[30:23];
         endcase
         v[30:23] = ex;
         return {shfc_pkg::FUNC_TO_HALF, v};
      end
      case ($urandom_range(5))
         0: hex = 5'd0;
         1: hex = 5'd31;
         default: hex = v[14:10];
      endcase
      v[14:10] = hex;
      if ($urandom_range(7) == 0) v[9:0] = 10'd0;
      return {shfc_pkg::FUNC_TO_SINGLE, v};
   endfunction

   initial begin
      logic [32:0] pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         push_request(DIRECTED[k][32], DIRECTED[k][31:0]);
      end
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300) begin
            // hold off until the pipeline has drained completely
            @(negedge clock);
            req_valid <= 1'b0;
            while (awaited != 0) @(posedge clock);
         end
         steady = (n >= 500 && n < 700);
         pick = random_request();
         push_request(pick[32], pick[31:0]);
      end
      steady = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
